[hw/rtl/geq_pkg.sv]
// Shared constants, codes and fixed-point helpers for the graphic equalizer biquad cascade.
package geq_pkg;

  // Structure
  localparam int NUM_BANDS      = 10;
  localparam int NUM_CHANNELS   = 2;
  localparam int COEFS_PER_BAND = 5;
  localparam int NCOEF          = NUM_BANDS * COEFS_PER_BAND;
  localparam int NROWS          = NUM_BANDS * NUM_CHANNELS;
  localparam int CA_W           = $clog2(NCOEF);
  localparam int RW             = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int BAND_W         = $clog2(NUM_BANDS + 1);

  // Field widths
  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 1;
  localparam int COEF_W     = 32;
  localparam int COEF_IDX_W = 6;

  // Datapath widths
  localparam int SIG_SHIFT  = 4;   // band signal is input * 16
  localparam int SIG_W      = 32;
  localparam int DLY_W      = 48;
  localparam int ACC_W      = 50;
  localparam int PROD_W     = 2 * SIG_W;
  localparam int MAC_W      = 56;
  localparam int FRAC_COEF  = 28;
  localparam int FRAC_MIX   = 20;
  localparam int RND_W      = MAC_W - FRAC_MIX;

  // Configuration registers
  localparam int WET_W     = 21;
  localparam int DRY_W     = 17;
  localparam int CFG_W     = 21;
  localparam int CFG_IDX_W = 1;
  localparam logic [WET_W-1:0] WET_RESET = WET_W'(65536);
  localparam logic [DRY_W-1:0] DRY_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET_GAIN = 1'b0,
    REG_DRY_GAIN = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  // floor((p + 2^27) / 2^28), sign-extended to accumulator width
  function automatic logic signed [ACC_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] rb;
    hi = {{(ACC_W-(PROD_W-FRAC_COEF)){p[PROD_W-1]}}, p[PROD_W-1:FRAC_COEF]};
    rb = {{(ACC_W-1){1'b0}}, p[FRAC_COEF-1]};
    return hi + rb;
  endfunction

  // floor((m + 2^19) / 2^20)
  function automatic logic signed [RND_W-1:0] round_mix(input logic signed [MAC_W-1:0] m);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] rb;
    hi = m[MAC_W-1:FRAC_MIX];
    rb = {{(RND_W-1){1'b0}}, m[FRAC_MIX-1]};
    return hi + rb;
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-SIG_W:0] top;
    top = v[ACC_W-1:SIG_W-1];
    if (top == '0 || top == '1) return v[SIG_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(SIG_W-1){1'b0}}};
    else return {1'b0, {(SIG_W-1){1'b1}}};
  endfunction

  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DLY_W:0] top;
    top = v[ACC_W-1:DLY_W-1];
    if (top == '0 || top == '1) return v[DLY_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(DLY_W-1){1'b0}}};
    else return {1'b0, {(DLY_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [RND_W-1:0] v);
    logic [RND_W-SAMPLE_W:0] top;
    top = v[RND_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) return v[SAMPLE_W-1:0];
    else if (v[RND_W-1]) return {1'b1, {(SAMPLE_W-1){1'b0}}};
    else return {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

[hw/rtl/geq_stream_if.sv]
// Valid/ready stream interfaces for equalizer input items and output samples.
interface geq_item_if;
  import geq_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [CHAN_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0]   sample_in;
  logic [COEF_IDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0]     coef_value;

  modport source (output valid, kind, channel, sample_in, coef_index, coef_value,
                  input ready);
  modport sink (input valid, kind, channel, sample_in, coef_index, coef_value,
                output ready);
endinterface

interface geq_result_if;
  import geq_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_W-1:0]   sample_out;
  logic [CHAN_W-1:0]            channel_out;

  modport source (output valid, sample_out, channel_out, input ready);
  modport sink (input valid, sample_out, channel_out, output ready);
endinterface

[hw/rtl/graphic_eq_biquad_cascade_unit.sv]
// Graphic equalizer: per-channel cascade of peaking biquads on one shared multiplier.
//
//  channel  | dir | handshake            | carries
//  ---------+-----+----------------------+-----------------------------------------------
//  item     | in  | valid / ready        | kind, channel, sample_in, coef_index, coef_value
//  result   | out | valid / ready        | sample_out, channel_out
//  cfg      | in  | cfg_wr_en (no stall) | cfg_index, cfg_data (wet_gain, dry_gain)
//
//  A sample runs through a six-step band loop on the single 32x32 multiplier, which does
//  five products per band, then two mix products, round and saturate.
//  Reset (rst, synchronous) clears control, gains, and the valid bits of the coefficient
//  and delay memories, so both read as zero at once; there is no clearing pass.
//  A finished sample waits in the output register; the next item is taken meanwhile, and
//  the last mix step holds only if that register is still full.
module graphic_eq_biquad_cascade_unit (
  input  logic                          clk,
  input  logic                          rst,
  geq_item_if.sink                      item,
  geq_result_if.source                  result,
  input  logic                          cfg_wr_en,
  input  logic [geq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [geq_pkg::CFG_W-1:0]     cfg_data
);
  import geq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BAND = 3'b010,
    S_MIX  = 3'b100
  } state_t;

  // band loop steps
  localparam logic [2:0] STEP_RD    = 3'd0;  // read row, retire previous band's acc2
  localparam logic [2:0] STEP_MUL0  = 3'd1;  // b0*x, write previous band's delays
  localparam logic [2:0] STEP_Y     = 3'd2;  // y = P0 + d1
  localparam logic [2:0] STEP_ACC1  = 3'd3;  // acc1 = P1 + d2
  localparam logic [2:0] STEP_ACC2  = 3'd4;  // acc2 = P2, x <= y
  localparam logic [2:0] STEP_LAST  = 3'd5;  // acc1 -= P3
  localparam logic [2:0] STEP_COEF_LAST = 3'd4;
  localparam logic [2:0] STEP_X_LAST    = 3'd3;
  // mix steps
  localparam logic [2:0] MIX_WET  = 3'd0;
  localparam logic [2:0] MIX_DRY  = 3'd1;
  localparam logic [2:0] MIX_SUM  = 3'd2;
  localparam logic [2:0] MIX_OUT  = 3'd3;

  // control
  state_t                state;
  logic [2:0]            step;
  logic [BAND_W-1:0]     band;
  logic [CA_W-1:0]       coef_base;
  logic [RW-1:0]         row;
  logic [RW-1:0]         prev_row;
  logic                  pass;
  logic                  out_valid;

  // configuration
  logic [WET_W-1:0]      wet_gain;
  logic [DRY_W-1:0]      dry_gain;

  // datapath
  logic [CHAN_W-1:0]          chan;
  logic signed [SAMPLE_W-1:0] dry;
  logic signed [SIG_W-1:0]    x;
  logic signed [SIG_W-1:0]    y;
  logic signed [ACC_W-1:0]    acc1;
  logic signed [ACC_W-1:0]    acc2;
  logic signed [PROD_W-1:0]   prod;
  logic signed [MAC_W-1:0]    macc;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [CHAN_W-1:0]          channel_out;

  // memories
  logic signed [COEF_W-1:0]   coef_mem [NCOEF];
  logic [NCOEF-1:0]           coef_vld;
  logic signed [COEF_W-1:0]   coef_rd;
  logic                       coef_rd_vld;
  logic [2*DLY_W-1:0]         dly_mem [NROWS];
  logic [NROWS-1:0]           dly_vld;
  logic [2*DLY_W-1:0]         dly_rd;
  logic                       dly_rd_vld;

  // combinational
  logic                       accept;
  logic                       coef_wr;
  logic [CA_W-1:0]            coef_wr_addr;
  logic                       coef_re;
  logic [CA_W-1:0]            coef_addr;
  logic                       dly_re;
  logic                       dly_we;
  logic [2*DLY_W-1:0]         dly_wdata;
  logic signed [COEF_W-1:0]   coef_use;
  logic signed [ACC_W-1:0]    d1_ext;
  logic signed [ACC_W-1:0]    d2_ext;
  logic signed [ACC_W-1:0]    term;
  logic signed [SIG_W-1:0]    mul_a;
  logic signed [SIG_W-1:0]    mul_b;
  logic signed [SIG_W-1:0]    dry16;
  logic signed [SIG_W-1:0]    in16;
  logic                       in_pass;
  logic                       band_last;
  logic                       out_load;

  assign item.ready         = (state == S_IDLE);
  assign accept             = item.valid && item.ready;
  assign result.valid       = out_valid;
  assign result.sample_out  = sample_out;
  assign result.channel_out = channel_out;

  assign in_pass   = int'(item.channel) >= NUM_CHANNELS;
  assign band_last = (band == BAND_W'(NUM_BANDS - 1));

  // coefficient writes only happen while idle, so they never meet a band read
  assign coef_wr      = accept && (item.kind == KIND_COEF) && (int'(item.coef_index) < NCOEF);
  assign coef_wr_addr = CA_W'(item.coef_index);
  assign coef_re      = (state == S_BAND) && (step <= STEP_COEF_LAST);
  assign coef_addr    = coef_base + CA_W'(step);

  // delay row of the band in flight is read at its first step; the row of the band
  // before is written back at STEP_MUL0 (different row)
  assign dly_re    = (state == S_BAND) && (step == STEP_RD);
  assign dly_we    = (((state == S_BAND) && (band != '0)) || (state == S_MIX))
                     && (step == STEP_MUL0);
  assign dly_wdata = {sat_dly(acc2), sat_dly(acc1)};

  // never-written entries read as zero
  assign coef_use = coef_rd_vld ? coef_rd : '0;
  assign d1_ext   = dly_rd_vld ? {{(ACC_W-DLY_W){dly_rd[DLY_W-1]}}, dly_rd[DLY_W-1:0]} : '0;
  assign d2_ext   = dly_rd_vld ?
                    {{(ACC_W-DLY_W){dly_rd[2*DLY_W-1]}}, dly_rd[2*DLY_W-1:DLY_W]} : '0;

  assign term  = round_prod(prod);
  assign dry16 = {{(SIG_W-SAMPLE_W-SIG_SHIFT){dry[SAMPLE_W-1]}}, dry, {SIG_SHIFT{1'b0}}};
  assign in16  = {{(SIG_W-SAMPLE_W-SIG_SHIFT){item.sample_in[SAMPLE_W-1]}},
                  item.sample_in, {SIG_SHIFT{1'b0}}};

  assign out_load = (state == S_MIX) && (step == MIX_OUT) && (!out_valid || result.ready);

  // shared multiplier operand select
  always_comb begin
    if (state == S_MIX) begin
      if (step == MIX_WET) begin
        mul_a = x;
        mul_b = {{(SIG_W-WET_W){1'b0}}, wet_gain};
      end else begin
        mul_a = dry16;
        mul_b = {{(SIG_W-DRY_W){1'b0}}, dry_gain};
      end
    end else begin
      mul_a = coef_use;
      mul_b = (step <= STEP_X_LAST) ? x : y;   // b0..b2 take x, a1/a2 take y
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_RD;
      band      <= '0;
      coef_base <= '0;
      row       <= '0;
      prev_row  <= '0;
      pass      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && item.kind == KIND_SAMPLE) begin
            band      <= '0;
            coef_base <= '0;
            row       <= RW'(int'(item.channel) * NUM_BANDS);
            pass      <= in_pass;
            // unfiltered channels go straight to the output step
            state     <= in_pass ? S_MIX : S_BAND;
            step      <= in_pass ? MIX_OUT : STEP_RD;
          end
        end
        S_BAND: begin
          if (step == STEP_LAST) begin
            step      <= STEP_RD;
            band      <= band + 1'b1;
            coef_base <= coef_base + CA_W'(COEFS_PER_BAND);
            prev_row  <= row;
            row       <= row + 1'b1;
            if (band_last) state <= S_MIX;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MIX: begin
          if (step != MIX_OUT) begin
            step <= step + 1'b1;
          end else if (out_load) begin
            state <= S_IDLE;
            step  <= STEP_RD;
          end
        end
        default: begin
          state <= S_IDLE;
          step  <= STEP_RD;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wet_gain <= WET_RESET;
      dry_gain <= DRY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WET_GAIN: wet_gain <= cfg_data[WET_W-1:0];
        REG_DRY_GAIN: dry_gain <= cfg_data[DRY_W-1:0];
      endcase
    end
  end

  // datapath: one product per cycle, registered, consumed at the next step
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (accept && item.kind == KIND_SAMPLE) begin
      chan <= item.channel;
      dry  <= item.sample_in;
      x    <= in16;
    end

    if (state == S_BAND) begin
      unique case (step)
        STEP_Y:    y    <= sat_sig(term + d1_ext);
        STEP_ACC1: acc1 <= term + d2_ext;
        STEP_ACC2: begin
          acc2 <= term;
          x    <= y;
        end
        STEP_LAST: acc1 <= acc1 - term;
        STEP_RD:   acc2 <= acc2 - term;   // a2 product of the band before
        default: ;
      endcase
    end

    if (state == S_MIX) begin
      unique case (step)
        MIX_WET: acc2 <= acc2 - term;     // last band's a2 product
        MIX_DRY: macc <= prod[MAC_W-1:0];
        MIX_SUM: macc <= macc + prod[MAC_W-1:0];
        default: ;
      endcase
    end

    if (out_load) begin
      sample_out  <= pass ? dry : sat_out(round_mix(macc));
      channel_out <= chan;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_wr) coef_mem[coef_wr_addr] <= item.coef_value;
    if (coef_re) begin
      coef_rd     <= coef_mem[coef_addr];
      coef_rd_vld <= coef_vld[coef_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
    end else if (coef_wr) begin
      coef_vld[coef_wr_addr] <= 1'b1;
    end
  end

  // delay memory: one row {d2, d1} per channel and band
  always_ff @(posedge clk) begin
    if (dly_we) dly_mem[prev_row] <= dly_wdata;
    if (dly_re) begin
      dly_rd     <= dly_mem[row];
      dly_rd_vld <= dly_vld[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_vld <= '0;
    end else if (dly_we) begin
      dly_vld[prev_row] <= 1'b1;
    end
  end

  // checks
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    accept && item.kind == KIND_SAMPLE |=> !item.ready)
    else $error("sample transfer did not start the band loop");

  a_coef_addr_range: assert property (@(posedge clk) disable iff (rst)
    coef_re |-> int'(coef_addr) < NCOEF)
    else $error("coefficient read beyond table");

  a_dly_row_range: assert property (@(posedge clk) disable iff (rst)
    dly_we |-> int'(prev_row) < NROWS && prev_row != row)
    else $error("delay write-back row out of range or clashes with read row");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_BAND |-> step <= STEP_LAST)
    else $error("band step counter out of range");

  a_hold_on_full_output: assert property (@(posedge clk) disable iff (rst)
    state == S_MIX && step == MIX_OUT && out_valid && !result.ready
    |=> state == S_MIX && step == MIX_OUT && result.valid)
    else $error("finished sample dropped while output register full");

endmodule
